>>> sv/mlla_pkg.sv
// Shared types, constants and the lux conversion table of the light alarm.
`default_nettype none
package mlla_pkg;

  localparam int WINDOW_LENGTH = 15;
  localparam int SAMPLE_BITS   = 10;
  localparam int POS_W         = $clog2(WINDOW_LENGTH);
  localparam int CNT_W         = $clog2(WINDOW_LENGTH + 1);
  localparam int MED_RANK      = WINDOW_LENGTH / 2;
  localparam int ROM_DEPTH     = 2 ** SAMPLE_BITS;
  localparam int LUX_W         = 12;
  localparam int CFG_W         = 12;
  localparam int CFG_IDX_W     = 3;
  localparam int QUO_W         = 12;
  localparam int NUM_W         = 24;
  localparam int STEP_W        = $clog2(QUO_W);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_LOW_LUX_THRESHOLD    = 3'd0,
    CFG_MANUAL_ALARM_WINDOWS = 3'd1,
    CFG_COLOR_KNEE           = 3'd2,
    CFG_FULL_SCALE_LUX       = 3'd3,
    CFG_LOW_GAIN             = 3'd4
  } cfg_idx_e;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_MEDIAN,
    BK_ROM,
    BK_CALC,
    BK_DIV,
    BK_FIN,
    BK_OUT
  } back_state_e;

  typedef struct packed {
    logic [SAMPLE_BITS-1:0] sample;
    logic                   alarm_request;
  } in_word_t;

  typedef struct packed {
    logic                   buzzer;
    logic                   report_valid;
    logic [SAMPLE_BITS-1:0] median_sample;
    logic [LUX_W-1:0]       lux;
    logic [7:0]             red_level;
    logic [7:0]             green_level;
    logic [7:0]             blue_level;
  } out_word_t;

  typedef struct packed {
    logic [SAMPLE_BITS-1:0] sample;
    logic                   req;
    logic [POS_W-1:0]       pos;
    logic                   close;
  } job_t;

  typedef struct packed {
    logic [11:0] threshold;
    logic [2:0]  windows;
    logic [11:0] knee;
    logic [11:0] full_scale;
    logic [3:0]  gain;
  } cfg_t;

  typedef logic [LUX_W-1:0] lux_rom_t [ROM_DEPTH];

  // Shift-and-subtract division, used only while the table is built.
  function automatic longint unsigned udiv64(longint unsigned n, longint unsigned d);
    longint unsigned quo;
    longint unsigned rem;
    quo = 64'd0;
    rem = 64'd0;
    for (int b = 63; b >= 0; b--) begin
      rem = {rem[62:0], n[b]};
      if (rem >= d) begin
        rem    = rem - d;
        quo[b] = 1'b1;
      end
    end
    return quo;
  endfunction

  // Fixed-point evaluation of 0.0236*exp(3.62*3.3*m/full), built at elaboration.
  function automatic lux_rom_t build_lux_rom();
    lux_rom_t          rom;
    longint unsigned   full;
    longint unsigned   xq;
    longint unsigned   q;
    longint unsigned   r;
    longint unsigned   e;
    longint unsigned   t;
    longint unsigned   v;
    longint unsigned   lux;
    full = (64'd1 << SAMPLE_BITS) - 64'd1;
    for (int m = 0; m < ROM_DEPTH; m++) begin
      xq = udiv64((64'd11946 * longint'(m)) << 32, 64'd1000 * full);
      // The exponent is small, so the ln2 split is a short subtraction loop.
      q  = 64'd0;
      r  = xq;
      while (r >= 64'd2977044472) begin
        r = r - 64'd2977044472;
        q = q + 64'd1;
      end
      e  = 64'd4294967296;
      t  = 64'd4294967296;
      for (int k = 1; k <= 24; k++) begin
        t = udiv64((t * r) >> 32, longint'(k));
        e = e + t;
      end
      if (q > 64'd20) q = 64'd20;
      v   = (64'd236 * e) << q;
      lux = udiv64(v >> 32, 64'd10000);
      rom[m] = (lux > 64'd4095) ? 12'd4095 : lux[LUX_W-1:0];
    end
    return rom;
  endfunction

  localparam lux_rom_t LUX_ROM = build_lux_rom();

endpackage
`default_nettype wire

>>> sv/mlla_front.sv
// Front end: tracks the window position of each word and queues jobs for the back end.
`default_nettype none
module mlla_front (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              push,
  output logic                   full,
  input  wire mlla_pkg::in_word_t data_i,
  output logic                   job_valid_o,
  output mlla_pkg::job_t         job_o,
  input  wire logic              job_pop_i
);

  logic [mlla_pkg::POS_W-1:0] fill_q, fill_d;
  mlla_pkg::job_t             mem_q [2];
  logic                       wr_q, rd_q;
  logic [1:0]                 cnt_q, cnt_d;
  logic                       do_push, do_pop;
  mlla_pkg::job_t             new_job;

  assign full        = (cnt_q == 2'd2);
  assign job_valid_o = (cnt_q != 2'd0);
  assign job_o       = mem_q[rd_q];
  assign do_push     = push && !full;
  assign do_pop      = job_pop_i && job_valid_o;

  always_comb begin
    new_job.sample = data_i.sample;
    new_job.req    = data_i.alarm_request;
    new_job.pos    = fill_q;
    new_job.close  = (fill_q == mlla_pkg::POS_W'(mlla_pkg::WINDOW_LENGTH - 1));
    fill_d = fill_q;
    if (do_push) begin
      fill_d = new_job.close ? '0 : fill_q + 1'b1;
    end
    cnt_d = cnt_q + {1'b0, do_push} - {1'b0, do_pop};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q <= '0;
      wr_q   <= 1'b0;
      rd_q   <= 1'b0;
      cnt_q  <= 2'd0;
    end else begin
      fill_q <= fill_d;
      cnt_q  <= cnt_d;
      if (do_push) wr_q <= ~wr_q;
      if (do_pop)  rd_q <= ~rd_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_q] <= new_job;
  end

endmodule
`default_nettype wire

>>> sv/mlla_back.sv
// Back end: window store, median search, lux table, colour divider and buzzer.
`default_nettype none
module mlla_back (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire mlla_pkg::cfg_t     cfg_i,
  input  wire logic               job_valid_i,
  input  wire mlla_pkg::job_t     job_i,
  output logic                    job_pop_o,
  output logic                    out_valid_o,
  output mlla_pkg::out_word_t     out_o,
  input  wire logic               pop_i
);

  localparam int SB = mlla_pkg::SAMPLE_BITS;
  localparam int WL = mlla_pkg::WINDOW_LENGTH;

  mlla_pkg::back_state_e      state_q, state_d;
  logic [SB-1:0]              win_q [WL];
  logic [mlla_pkg::POS_W-1:0] cand_q, cand_d;
  logic [SB-1:0]              med_q, med_d;
  logic [11:0]                lux_q;
  logic                       buz_q, buz_d;
  logic [2:0]                 cd_q, cd_d;
  logic                       knee_q, knee_d;
  logic [11:0]                rem_q, rem_d;
  logic [11:0]                sh_q, sh_d;
  logic [mlla_pkg::STEP_W-1:0] step_q, step_d;
  mlla_pkg::out_word_t        res_q, res_d;
  mlla_pkg::out_word_t        out_q, out_d;
  logic                       out_valid_q, out_valid_d;

  logic [SB-1:0]              cand_val;
  logic [mlla_pkg::CNT_W-1:0] n_less, n_le;
  logic [11:0]                fs_eff;
  logic [11:0]                factor;
  logic [mlla_pkg::NUM_W-1:0] num;
  logic [12:0]                r2;
  logic                       ge;
  logic [7:0]                 bg;
  logic                       nb_buz;
  logic [2:0]                 nb_cd;

  assign cand_val = win_q[cand_q];
  assign fs_eff   = (cfg_i.full_scale == 12'd0) ? 12'd1 : cfg_i.full_scale;

  // Rank of the candidate: entries strictly below it and entries not above it.
  always_comb begin
    n_less = '0;
    n_le   = '0;
    for (int j = 0; j < WL; j++) begin
      n_less = n_less + mlla_pkg::CNT_W'(win_q[j] <  cand_val);
      n_le   = n_le   + mlla_pkg::CNT_W'(win_q[j] <= cand_val);
    end
  end

  always_comb begin
    state_d     = state_q;
    cand_d      = cand_q;
    med_d       = med_q;
    buz_d       = buz_q;
    cd_d        = cd_q;
    knee_d      = knee_q;
    rem_d       = rem_q;
    sh_d        = sh_q;
    step_d      = step_q;
    res_d       = res_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && !pop_i;
    job_pop_o   = 1'b0;
    nb_buz      = buz_q;
    nb_cd       = cd_q;
    factor      = 12'd255;
    num         = '0;
    r2          = {rem_q, sh_q[11]};
    ge          = (r2 >= {1'b0, fs_eff});
    bg          = 8'd0;

    unique case (state_q)
      mlla_pkg::BK_IDLE: begin
        job_pop_o = job_valid_i;
        if (job_valid_i) begin
          if (job_i.req) begin
            nb_buz = 1'b1;
            nb_cd  = cfg_i.windows;
          end
          buz_d = nb_buz;
          if (job_i.close) begin
            cd_d    = (nb_cd != 3'd0) ? nb_cd - 3'd1 : 3'd0;
            cand_d  = '0;
            state_d = mlla_pkg::BK_MEDIAN;
          end else begin
            cd_d    = nb_cd;
            res_d   = '0;
            state_d = mlla_pkg::BK_OUT;
          end
        end
      end
      mlla_pkg::BK_MEDIAN: begin
        if (n_less <= mlla_pkg::CNT_W'(mlla_pkg::MED_RANK) &&
            n_le > mlla_pkg::CNT_W'(mlla_pkg::MED_RANK)) begin
          med_d   = cand_val;
          state_d = mlla_pkg::BK_ROM;
        end else begin
          cand_d = cand_q + 1'b1;
        end
      end
      mlla_pkg::BK_ROM: begin
        state_d = mlla_pkg::BK_CALC;
      end
      mlla_pkg::BK_CALC: begin
        if (lux_q < cfg_i.threshold) begin
          buz_d = 1'b1;
        end else if (cd_q == 3'd0) begin
          buz_d = 1'b0;
        end
        knee_d = (lux_q <= cfg_i.knee);
        res_d               = '0;
        res_d.report_valid  = 1'b1;
        res_d.median_sample = med_q;
        res_d.lux           = lux_q;
        if (lux_q > fs_eff) begin
          res_d.red_level   = 8'd255;
          bg                = (cfg_i.gain == 4'd0) ? 8'd0 : 8'd255;
          res_d.green_level = knee_d ? 8'd255 - bg : 8'd0;
          res_d.blue_level  = res_d.green_level;
          state_d           = mlla_pkg::BK_OUT;
        end else begin
          factor  = knee_d ? 12'(cfg_i.gain) * 12'd255 : 12'd255;
          num     = mlla_pkg::NUM_W'(factor) * mlla_pkg::NUM_W'(lux_q);
          rem_d   = num[23:12];
          sh_d    = num[11:0];
          step_d  = '0;
          state_d = mlla_pkg::BK_DIV;
        end
      end
      mlla_pkg::BK_DIV: begin
        rem_d  = ge ? 12'(r2 - {1'b0, fs_eff}) : r2[11:0];
        sh_d   = {sh_q[10:0], ge};
        step_d = step_q + 1'b1;
        if (step_q == mlla_pkg::STEP_W'(mlla_pkg::QUO_W - 1)) begin
          state_d = mlla_pkg::BK_FIN;
        end
      end
      mlla_pkg::BK_FIN: begin
        if (knee_q) begin
          bg                = (sh_q > 12'd255) ? 8'd255 : sh_q[7:0];
          res_d.red_level   = 8'd255;
          res_d.green_level = 8'd255 - bg;
        end else begin
          res_d.red_level   = sh_q[7:0];
          res_d.green_level = 8'd0;
        end
        res_d.blue_level = res_d.green_level;
        state_d          = mlla_pkg::BK_OUT;
      end
      mlla_pkg::BK_OUT: begin
        if (!out_valid_q || pop_i) begin
          out_d        = res_q;
          out_d.buzzer = buz_q;
          out_valid_d  = 1'b1;
          state_d      = mlla_pkg::BK_IDLE;
        end
      end
      default: state_d = mlla_pkg::BK_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= mlla_pkg::BK_IDLE;
      buz_q       <= 1'b0;
      cd_q        <= 3'd0;
      out_valid_q <= 1'b0;
      cand_q      <= '0;
      step_q      <= '0;
    end else begin
      state_q     <= state_d;
      buz_q       <= buz_d;
      cd_q        <= cd_d;
      out_valid_q <= out_valid_d;
      cand_q      <= cand_d;
      step_q      <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    med_q  <= med_d;
    knee_q <= knee_d;
    rem_q  <= rem_d;
    sh_q   <= sh_d;
    res_q  <= res_d;
    out_q  <= out_d;
    if (state_q == mlla_pkg::BK_IDLE && job_valid_i) begin
      win_q[job_i.pos] <= job_i.sample;
    end
    if (state_q == mlla_pkg::BK_ROM) begin
      lux_q <= mlla_pkg::LUX_ROM[med_q];
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

  a_cand_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == mlla_pkg::BK_MEDIAN |-> cand_q < mlla_pkg::POS_W'(WL))
    else $error("median search ran past the window");

  a_plain_word_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !out_q.report_valid |->
      out_q.lux == '0 && out_q.median_sample == '0 && out_q.red_level == '0)
    else $error("word without a report carries report fields");

  a_green_needs_red: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_q.green_level != 8'd0 |-> out_q.red_level == 8'd255)
    else $error("green set while red is not full");

  a_div_length: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == mlla_pkg::BK_DIV && step_q == mlla_pkg::STEP_W'(mlla_pkg::QUO_W - 1)
      |=> state_q == mlla_pkg::BK_FIN)
    else $error("divider did not finish after its last step");

endmodule
`default_nettype wire

>>> sv/median_light_level_alarm_top.sv
// Top level of the median light-level alarm: configuration registers and the two halves.
//
// Input words (sample, alarm request) are pushed while full is low; a two-word
// job queue behind the input lets the front keep taking words while the back
// end works. Each word yields exactly one result word, read with pop while
// empty is low; the result is held in an output register until popped.
// A word that does not close the 15-sample window passes from queue head
// through the output state to the output register. A closing word goes through
// the median search (one candidate ranked against the whole window per cycle),
// the lux table read, the buzzer and colour set-up, the bit-serial colour
// divider (skipped when lux is above full scale) and a finishing step; the
// median search and the divider together set the rate for closing words.
// When the reader stalls, the back end waits with its finished word and the
// job queue fills, after which full rises.
// Reset clears the queues, the window position, the countdown and the buzzer,
// and loads the configuration defaults. Configuration is written through a
// plain write port with no handshake; indexes beyond the list are ignored.
`default_nettype none
module median_light_level_alarm_top (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            push,
  output logic                                 full,
  input  wire mlla_pkg::in_word_t              data_i,
  output logic                                 empty,
  input  wire logic                            pop,
  output mlla_pkg::out_word_t                  data_o,
  input  wire logic                            cfg_we_i,
  input  wire logic [mlla_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [mlla_pkg::CFG_W-1:0]      cfg_wdata_i
);

  mlla_pkg::cfg_t cfg_q;
  logic           job_valid;
  mlla_pkg::job_t job;
  logic           job_pop;
  logic           out_valid;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.threshold  <= 12'd150;
      cfg_q.windows    <= 3'd5;
      cfg_q.knee       <= 12'd250;
      cfg_q.full_scale <= 12'd3000;
      cfg_q.gain       <= 4'd10;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        mlla_pkg::CFG_LOW_LUX_THRESHOLD:    cfg_q.threshold  <= cfg_wdata_i;
        mlla_pkg::CFG_MANUAL_ALARM_WINDOWS: cfg_q.windows    <= cfg_wdata_i[2:0];
        mlla_pkg::CFG_COLOR_KNEE:           cfg_q.knee       <= cfg_wdata_i;
        mlla_pkg::CFG_FULL_SCALE_LUX:       cfg_q.full_scale <= cfg_wdata_i;
        mlla_pkg::CFG_LOW_GAIN:             cfg_q.gain       <= cfg_wdata_i[3:0];
        default: ;
      endcase
    end
  end

  mlla_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push        (push),
    .full        (full),
    .data_i      (data_i),
    .job_valid_o (job_valid),
    .job_o       (job),
    .job_pop_i   (job_pop)
  );

  mlla_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .job_valid_i (job_valid),
    .job_i       (job),
    .job_pop_o   (job_pop),
    .out_valid_o (out_valid),
    .out_o       (data_o),
    .pop_i       (pop)
  );

  assign empty = !out_valid;

endmodule
`default_nettype wire

>>> dv/median_light_level_alarm_top_tb.sv
// Self-checking testbench for the median light-level alarm top level.
`default_nettype none
module median_light_level_alarm_top_tb;

  localparam int SB = mlla_pkg::SAMPLE_BITS;
  localparam int WL = mlla_pkg::WINDOW_LENGTH;
  localparam int LW = mlla_pkg::LUX_W;
  localparam int IW = mlla_pkg::CFG_IDX_W;
  localparam int CW = mlla_pkg::CFG_W;

  localparam int WATCHDOG_LIMIT = 3000;
  localparam int DRAIN_CYCLES   = 60;
  localparam int RANDOM_WORDS   = 270;
  localparam logic [IW-1:0] CFG_UNUSED_IDX = 3'd7;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 push;
  logic                 full;
  mlla_pkg::in_word_t   data_i;
  logic                 empty;
  logic                 pop;
  mlla_pkg::out_word_t  data_o;
  logic                 cfg_we_i;
  logic [IW-1:0]        cfg_idx_i;
  logic [CW-1:0]        cfg_wdata_i;

  median_light_level_alarm_top dut (
    .clk_i, .rst_ni, .push, .full, .data_i, .empty, .pop, .data_o,
    .cfg_we_i, .cfg_idx_i, .cfg_wdata_i
  );

  // Model state and configuration.
  logic [SB-1:0]          win_store [WL];
  int unsigned            win_pos;
  int unsigned            countdown;
  logic                   buzz;
  int unsigned            thr_cfg, windows_cfg, knee_cfg, fs_cfg, gain_cfg;

  mlla_pkg::out_word_t pending_words [$];
  int          error_count;
  int          idle_cycles;
  int          hold_request;
  bit          allow_stall;
  int          words_sent, words_read, reports_seen, buzzer_on_seen;

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  function automatic logic [LW-1:0] lux_of_median(int unsigned m);
    longint unsigned xq, q, r, e, t, v, l;
    xq = ((64'd11946 * m) << 32) / (64'd1000 * ((64'd1 << SB) - 1));
    q  = xq / 64'd2977044472;
    r  = xq - q * 64'd2977044472;
    e  = 64'd1 << 32;
    t  = 64'd1 << 32;
    for (int k = 1; k <= 24; k++) begin
      t = ((t * r) >> 32) / k;
      e += t;
    end
    if (q > 20) q = 20;
    v = (64'd236 * e) << q;
    l = v / (64'd10000 << 32);
    return (l > 4095) ? LW'(4095) : LW'(l);
  endfunction

  function automatic int unsigned window_median_value();
    int unsigned s [WL];
    int unsigned tmp;
    for (int i = 0; i < WL; i++) s[i] = win_store[i];
    for (int i = 0; i < WL; i++)
      for (int j = 0; j < WL - 1 - i; j++)
        if (s[j] > s[j+1]) begin
          tmp = s[j]; s[j] = s[j+1]; s[j+1] = tmp;
        end
    return s[WL/2];
  endfunction

  // Advances the model by one accepted word and returns the expected result.
  function automatic mlla_pkg::out_word_t alarm_result(mlla_pkg::in_word_t w);
    mlla_pkg::out_word_t o;
    int unsigned fs, lux, bg;
    o = '0;
    if (win_pos >= WL) win_pos = 0;
    win_store[win_pos] = w.sample;
    if (w.alarm_request) begin
      buzz = 1'b1;
      countdown = windows_cfg;
    end
    if (win_pos == WL - 1) begin
      fs = (fs_cfg != 0) ? fs_cfg : 1;
      if (countdown > 0) countdown--;
      o.report_valid  = 1'b1;
      o.median_sample = SB'(window_median_value());
      lux = lux_of_median(o.median_sample);
      o.lux = LW'(lux);
      if (lux <= knee_cfg) begin
        bg = (lux > fs) ? 255 * gain_cfg : (255 * gain_cfg * lux) / fs;
        if (bg > 255) bg = 255;
        o.red_level   = 8'd255;
        o.green_level = 8'(255 - bg);
      end else begin
        o.red_level   = (lux > fs) ? 8'd255 : 8'((255 * lux) / fs);
        o.green_level = 8'd0;
      end
      o.blue_level = o.green_level;
      if (lux < thr_cfg) buzz = 1'b1;
      else if (countdown == 0) buzz = 1'b0;
      win_pos = 0;
    end else begin
      win_pos++;
    end
    o.buzzer = buzz;
    return o;
  endfunction

  task automatic report_mismatch(string field, int unsigned got, int unsigned want);
    $display("MISMATCH result %0d field %s: got %0d, expected %0d",
             words_read, field, got, want);
    error_count++;
  endtask

  task automatic compare_word(mlla_pkg::out_word_t got, mlla_pkg::out_word_t want);
    if (got.buzzer !== want.buzzer) report_mismatch("buzzer", got.buzzer, want.buzzer);
    if (got.report_valid !== want.report_valid)
      report_mismatch("report_valid", got.report_valid, want.report_valid);
    if (got.median_sample !== want.median_sample)
      report_mismatch("median_sample", got.median_sample, want.median_sample);
    if (got.lux !== want.lux) report_mismatch("lux", got.lux, want.lux);
    if (got.red_level !== want.red_level)
      report_mismatch("red_level", got.red_level, want.red_level);
    if (got.green_level !== want.green_level)
      report_mismatch("green_level", got.green_level, want.green_level);
    if (got.blue_level !== want.blue_level)
      report_mismatch("blue_level", got.blue_level, want.blue_level);
  endtask

  // Result side: random pop gaps, now and then a longer one, plus a long hold-off on request.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty) begin
        if (pending_words.size() == 0) begin
          report_mismatch("unexpected word", 1, 0);
        end else begin
          compare_word(data_o, pending_words.pop_front());
        end
        if (data_o.report_valid) reports_seen++;
        if (data_o.buzzer) buzzer_on_seen++;
        words_read++;
      end
      if (hold_request > 0) begin
        hold_request--;
        pop <= 1'b0;
      end else if (allow_stall) begin
        if ($urandom_range(0, 63) == 0) hold_request = $urandom_range(15, 60);
        pop <= ($urandom_range(0, 3) != 0);
      end else begin
        pop <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (push && !full) || (pop && !empty)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("Timeout: no word moved for %0d cycles", WATCHDOG_LIMIT);
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

  function automatic int unsigned gap_length();
    if (!allow_stall) return 0;
    if ($urandom_range(0, 19) == 0) return $urandom_range(15, 60);
    return $urandom_range(0, 2);
  endfunction

  task automatic send_word(logic [SB-1:0] smp, logic req);
    int unsigned gap;
    push <= 1'b1;
    data_i <= '{sample: smp, alarm_request: req};
    do @(posedge clk_i); while (full);
    pending_words.push_back(alarm_result('{sample: smp, alarm_request: req}));
    words_sent++;
    gap = gap_length();
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic wait_idle();
    push <= 1'b0;
    while (pending_words.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [IW-1:0] idx, int unsigned val);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= CW'(val);
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      mlla_pkg::CFG_LOW_LUX_THRESHOLD:    thr_cfg     = val & 12'hFFF;
      mlla_pkg::CFG_MANUAL_ALARM_WINDOWS: windows_cfg = val & 3'h7;
      mlla_pkg::CFG_COLOR_KNEE:           knee_cfg    = val & 12'hFFF;
      mlla_pkg::CFG_FULL_SCALE_LUX:       fs_cfg      = val & 12'hFFF;
      mlla_pkg::CFG_LOW_GAIN:             gain_cfg    = val & 4'hF;
      default: ;
    endcase
  endtask

  // Samples spread to land lux around the knee and the threshold as well as the ends.
  function automatic logic [SB-1:0] pick_sample();
    case ($urandom_range(0, 3))
      0: return SB'($urandom_range(0, 1023));
      1: return SB'($urandom_range(700, 900));
      2: return SB'($urandom_range(900, 1023));
      default: return SB'($urandom_range(0, 200));
    endcase
  endfunction

  task automatic test_directed_extremes();
    // One full window of extremes with a request, then a partial window.
    for (int i = 0; i < WL; i++)
      send_word((i % 2) ? SB'(1023) : SB'(0), i == 3);
    for (int i = 0; i < 8; i++) send_word(SB'(1023 - i), 1'b0);
    wait_idle();
  endtask

  task automatic run_windows(int unsigned count);
    for (int w = 0; w < count; w++)
      for (int i = 0; i < WL; i++)
        send_word(pick_sample(), $urandom_range(0, 7) == 0);
  endtask

  task automatic test_config_settings();
    write_reg(CFG_UNUSED_IDX, 12'hFFF);
    write_reg(mlla_pkg::CFG_LOW_LUX_THRESHOLD, 0);
    write_reg(mlla_pkg::CFG_MANUAL_ALARM_WINDOWS, 0);
    write_reg(mlla_pkg::CFG_COLOR_KNEE, 0);
    write_reg(mlla_pkg::CFG_FULL_SCALE_LUX, 0);
    write_reg(mlla_pkg::CFG_LOW_GAIN, 0);
    run_windows(3);
    wait_idle();
    write_reg(mlla_pkg::CFG_LOW_LUX_THRESHOLD, 4095);
    write_reg(mlla_pkg::CFG_MANUAL_ALARM_WINDOWS, 7);
    write_reg(mlla_pkg::CFG_COLOR_KNEE, 4095);
    write_reg(mlla_pkg::CFG_FULL_SCALE_LUX, 4095);
    write_reg(mlla_pkg::CFG_LOW_GAIN, 15);
    run_windows(3);
    wait_idle();
    write_reg(mlla_pkg::CFG_LOW_LUX_THRESHOLD, 40);
    write_reg(mlla_pkg::CFG_MANUAL_ALARM_WINDOWS, 2);
    write_reg(mlla_pkg::CFG_COLOR_KNEE, 100);
    write_reg(mlla_pkg::CFG_FULL_SCALE_LUX, 1);
    write_reg(mlla_pkg::CFG_LOW_GAIN, 1);
    run_windows(3);
    wait_idle();
  endtask

  task automatic test_random_stream();
    write_reg(mlla_pkg::CFG_LOW_LUX_THRESHOLD, $urandom_range(0, 400));
    write_reg(mlla_pkg::CFG_MANUAL_ALARM_WINDOWS, $urandom_range(0, 7));
    write_reg(mlla_pkg::CFG_COLOR_KNEE, $urandom_range(0, 1500));
    write_reg(mlla_pkg::CFG_FULL_SCALE_LUX, $urandom_range(1, 4095));
    write_reg(mlla_pkg::CFG_LOW_GAIN, $urandom_range(1, 15));
    allow_stall = 1'b1;
    for (int i = 0; i < RANDOM_WORDS; i++) begin
      // Occasional stretches where neither side idles.
      if (i % 100 == 50) allow_stall = 1'b0;
      if (i % 100 == 80) allow_stall = 1'b1;
      send_word(pick_sample(), $urandom_range(0, 9) == 0);
    end
    wait_idle();
  endtask

  task automatic test_backpressure();
    // The reader holds off while words keep coming, so the input has to stall.
    hold_request = 400;
    for (int i = 0; i < 2 * WL; i++) send_word(pick_sample(), i == 5);
    wait_idle();
  endtask

  initial begin
    rst_ni = 1'b0;
    push = 1'b0;
    data_i = '0;
    cfg_we_i = 1'b0;
    cfg_idx_i = mlla_pkg::CFG_LOW_LUX_THRESHOLD;
    cfg_wdata_i = '0;
    error_count = 0; idle_cycles = 0; hold_request = 0; allow_stall = 1'b0;
    words_sent = 0; words_read = 0; reports_seen = 0; buzzer_on_seen = 0;
    win_pos = 0; countdown = 0; buzz = 1'b0;
    thr_cfg = 150; windows_cfg = 5; knee_cfg = 250; fs_cfg = 3000; gain_cfg = 10;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    test_directed_extremes();
    allow_stall = 1'b1;
    test_config_settings();
    test_random_stream();
    test_backpressure();

    $display("Covered %0d words in, %0d results out, %0d window reports,",
             words_sent, words_read, reports_seen);
    $display("%0d results with the buzzer on, across default, extreme and random settings.",
             buzzer_on_seen);
    if (error_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("%0d mismatches", error_count);
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
`default_nettype wire
